@@ hw/rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the code point to UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int CP_W       = 21;  // code points below 0x110000
    localparam int SURR_W     = 10;  // payload bits of a surrogate
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 6;   // held unit (3) plus a BMP unit (3)
    localparam int CNT_W      = 3;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;  // 0xDC00..0xDFFF
    localparam logic [31:0] CP_LIMIT      = 32'h0011_0000;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;

    localparam logic [7:0] LEAD_1 = 8'h00;
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    // One queue entry: an optional held high surrogate to flush as 3 bytes,
    // then an optional code point.
    typedef struct packed {
        logic              has_held;
        logic [SURR_W-1:0] held_bits;
        logic              has_cp;
        logic [CP_W-1:0]   cp;
    } job_t;

    typedef struct packed {
        logic [CNT_W-1:0]       len;
        logic [3:0][BYTE_W-1:0] b;    // b[0] goes out first
    } enc_t;

    function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e.b = '0;
        if (cp < 21'h00_0080) begin
            e.len  = 3'd1;
            e.b[0] = LEAD_1 | {1'b0, cp[6:0]};
        end
        else if (cp < 21'h00_0800) begin
            e.len  = 3'd2;
            e.b[0] = LEAD_2 | {3'b0, cp[10:6]};
            e.b[1] = CONT | {2'b0, cp[5:0]};
        end
        else if (cp < 21'h01_0000) begin
            e.len  = 3'd3;
            e.b[0] = LEAD_3 | {4'b0, cp[15:12]};
            e.b[1] = CONT | {2'b0, cp[11:6]};
            e.b[2] = CONT | {2'b0, cp[5:0]};
        end
        else begin
            e.len  = 3'd4;
            e.b[0] = LEAD_4 | {5'b0, cp[20:18]};
            e.b[1] = CONT | {2'b0, cp[17:12]};
            e.b[2] = CONT | {2'b0, cp[11:6]};
            e.b[3] = CONT | {2'b0, cp[5:0]};
        end
        return e;
    endfunction

endpackage

@@ hw/rtl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accept code units, pair surrogates and post encode jobs to the queue.
// ----------------------------------------------------------------------------
module u16u8_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  fire,
    input  logic [31:0]           code_unit,
    input  logic                  last_unit,
    output logic                  push,
    output u16u8_pkg::job_t       job
);

    logic                          wide_reg;
    logic                          held_valid_reg;
    logic                          held_valid_next;
    logic [u16u8_pkg::SURR_W-1:0]  held_bits_reg;
    logic [u16u8_pkg::SURR_W-1:0]  held_bits_next;
    logic [15:0]                   u;
    logic                          is_high;
    logic                          is_low;

    assign u       = code_unit[15:0];
    assign is_high = (u[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign is_low  = (u[15:10] == u16u8_pkg::LOW_SURR_TAG);

    always_comb
    begin
        job             = '0;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (wide_reg)
        begin
            job.has_cp = (code_unit < u16u8_pkg::CP_LIMIT);
            job.cp     = code_unit[u16u8_pkg::CP_W-1:0];
        end
        else if (held_valid_reg && is_low)
        begin
            // join the pair
            job.has_cp      = 1'b1;
            job.cp          = u16u8_pkg::SUPP_BASE + {1'b0, held_bits_reg, u[9:0]};
            held_valid_next = 1'b0;
            held_bits_next  = '0;
        end
        else
        begin
            // flush any held unit, then hold or encode the new one
            job.has_held    = held_valid_reg;
            job.held_bits   = held_bits_reg;
            held_valid_next = 1'b0;
            held_bits_next  = '0;
            if (is_high && !last_unit)
            begin
                held_valid_next = 1'b1;
                held_bits_next  = u[9:0];
            end
            else
            begin
                job.has_cp = 1'b1;
                job.cp     = {5'b0, u};
            end
        end
    end

    assign push = fire && (job.has_held || job.has_cp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            wide_reg       <= cfg_wr_data;
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else if (fire)
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

@@ hw/rtl/u16u8_fifo.sv @@
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u16u8_pkg::job_t   push_job,
    input  logic              pop,
    output u16u8_pkg::job_t   head_job,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Expand one queued job into its UTF-8 bytes and stream them out.
// ----------------------------------------------------------------------------
module u16u8_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  u16u8_pkg::job_t   head_job,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic [u16u8_pkg::MAX_BYTES-1:0][7:0] buf_reg;
    logic [u16u8_pkg::MAX_BYTES-1:0][7:0] buf_next;
    logic [u16u8_pkg::CNT_W-1:0]          cnt_reg;
    logic [u16u8_pkg::CNT_W-1:0]          cnt_next;
    logic [u16u8_pkg::CNT_W-1:0]          idx_reg;
    logic                                 busy_reg;
    logic                                 at_last;
    logic                                 beat;
    u16u8_pkg::enc_t                      held_enc;
    u16u8_pkg::enc_t                      cp_enc;

    assign held_enc = u16u8_pkg::encode_cp({5'b0, u16u8_pkg::HIGH_SURR_TAG,
                                            head_job.held_bits});
    assign cp_enc   = u16u8_pkg::encode_cp(head_job.cp);

    always_comb
    begin
        buf_next = '0;
        cnt_next = '0;
        if (head_job.has_held)
        begin
            buf_next[0] = held_enc.b[0];
            buf_next[1] = held_enc.b[1];
            buf_next[2] = held_enc.b[2];
            buf_next[3] = cp_enc.b[0];
            buf_next[4] = cp_enc.b[1];
            buf_next[5] = cp_enc.b[2];
            cnt_next    = 3'd3 + (head_job.has_cp ? cp_enc.len : 3'd0);
        end
        else
        begin
            buf_next[0] = cp_enc.b[0];
            buf_next[1] = cp_enc.b[1];
            buf_next[2] = cp_enc.b[2];
            buf_next[3] = cp_enc.b[3];
            cnt_next    = head_job.has_cp ? cp_enc.len : 3'd0;
        end
    end

    assign at_last  = (idx_reg == cnt_reg - 1'b1);
    assign beat     = busy_reg && m_tready;
    assign pop      = !empty && (!busy_reg || (beat && at_last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = buf_reg[idx_reg];
    assign m_tlast  = at_last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (beat)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/utf16_to_utf8_encoder_core.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// Convert UTF-16 code units or 32-bit code points into a UTF-8 byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one code unit per beat (tdata = code_unit, tlast = last
//   unit of the string). m_* carries one UTF-8 byte per beat, with tlast
//   set on the final byte caused by one input unit.
//   cfg_wr_en/cfg_wr_data write wide_units (0 = UTF-16 with surrogate
//   pairing, 1 = 32-bit code points); a write also drops a held surrogate.
//   Write it only while the block is idle.
// Timing:
//   The front end takes one unit per cycle while the job queue has room and
//   posts a job in the same cycle. The job is registered in the queue, then
//   popped into the back end's byte buffer when that is free, then sent out.
//   The back end sends one byte per cycle while m_tready is high and loads
//   the next job on the beat of the last byte; a job holds 1 to 6 bytes. A
//   unit that is only held, or a code point past U+10FFFF, posts no job. The
//   byte count of each job sets the sustained rate.
// Reset clears the mode, the held surrogate, the queue and the output.
// When the receiver stalls, the current byte holds, the queue fills, and
// s_tready drops once QUEUE_DEPTH jobs wait.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // wide_units
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] code_unit
    input  logic        s_tlast,       // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] utf8_byte
    output logic        m_tlast        // last_byte
);

    u16u8_pkg::job_t push_job;
    u16u8_pkg::job_t head_job;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            in_fire;

    // accept a unit whenever the queue can take its job
    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    u16u8_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (in_fire),
        .code_unit   (s_tdata),
        .last_unit   (s_tlast),
        .push        (push),
        .job         (push_job)
    );

    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    u16u8_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/tb_utf16_to_utf8_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder_core
// Self-checking bench for the UTF-16 / code point to UTF-8 encoder.
// ----------------------------------------------------------------------------
// A directed pass covers the byte-length boundaries, surrogate pairing,
// lone and interrupted surrogates and out-of-range code points in both
// modes. Random phases follow with mostly well-formed text plus broken
// pairs and raw noise, under changing sender idle and receiver stall rates.
// Every accepted unit is run through a local encoder model; every accepted
// byte is checked against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder_core;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;   // well past the encoder latency
    localparam int REPORT_MAX    = 10;

    localparam bit MODE_UTF16 = 1'b0;
    localparam bit MODE_WIDE  = 1'b1;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_END   = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_END    = 16'hDFFF;

    // ------------------------------------------------------------------------
    // Byte tracker: predicts the UTF-8 bytes of each accepted unit and
    // checks the bytes the block sends against them in order.
    // ------------------------------------------------------------------------
    class utf8_stream_checker;
        bit       wide_mode;
        bit       held_valid;
        bit [9:0] held_bits;
        bit [8:0] pending_utf8[$];   // {last_byte, utf8_byte}
        int       errors;

        // A mode write also drops a held high surrogate.
        function void set_mode(input bit wide);
            wide_mode  = wide;
            held_valid = 1'b0;
            held_bits  = '0;
        endfunction

        function void push_byte(input bit [7:0] b);
            bit [8:0] entry;
            entry        = {1'b0, b};
            pending_utf8 = {pending_utf8, entry};
        endfunction

        // Append the bytes of one code point; 0x110000 and up give nothing.
        function void encode_code_point(input bit [31:0] cp);
            if (cp < 32'h80) begin
                push_byte(cp[7:0]);
            end
            else if (cp < 32'h800) begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else if (cp < 32'h1_0000) begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else if (cp < 32'h11_0000) begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
        endfunction

        function void note_unit(input bit [31:0] unit, input bit last);
            int       first_new;
            bit [15:0] u;
            bit        is_high;
            bit        is_low;
            bit        paired;
            bit [8:0]  tail;
            first_new = pending_utf8.size();
            u         = unit[15:0];
            is_high   = (u >= HIGH_FIRST) && (u <= HIGH_END);
            is_low    = (u >= LOW_FIRST) && (u <= LOW_END);
            paired    = 1'b0;
            if (wide_mode) begin
                encode_code_point(unit);
            end
            else begin
                if (held_valid) begin
                    if (is_low) begin
                        encode_code_point(32'h1_0000 + {12'b0, held_bits, 10'b0}
                                          + {16'b0, u - LOW_FIRST});
                        paired = 1'b1;
                    end
                    else begin
                        encode_code_point({16'b0, HIGH_FIRST | {6'b0, held_bits}});
                    end
                    held_valid = 1'b0;
                    held_bits  = '0;
                end
                if (!paired) begin
                    if (is_high && !last) begin
                        held_valid = 1'b1;
                        held_bits  = u[9:0];
                    end
                    else begin
                        encode_code_point({16'b0, u});
                    end
                end
            end
            // Mark the final byte caused by this unit.
            if (pending_utf8.size() > first_new) begin
                tail         = pending_utf8.pop_back();
                tail[8]      = 1'b1;
                pending_utf8 = {pending_utf8, tail};
            end
        endfunction

        function void fail(input string what);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_byte(input bit [7:0] data, input bit last);
            bit [8:0] want;
            if (pending_utf8.size() == 0) begin
                fail($sformatf("unexpected byte %02h last %0d", data, last));
                return;
            end
            want = pending_utf8.pop_front();
            if (want[7:0] != data || want[8] != last)
                fail($sformatf("byte mismatch: expected %02h last %0d, got %02h last %0d",
                               want[7:0], want[8], data, last));
        endfunction

        function int pending();
            return pending_utf8.size();
        endfunction

        function void close_out();
            if (pending_utf8.size() != 0)
                fail($sformatf("%0d expected bytes never arrived", pending_utf8.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [31:0] code_unit
    logic        s_tlast;      // last_unit
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;      // [7:0] utf8_byte
    logic        m_tlast;      // last_byte

    utf16_to_utf8_encoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    utf8_stream_checker tracker = new();

    int tx_idle_pct;     // chance per draw that the sender idles once more before a beat
    int rx_stall_pct;    // chance per cycle that the receiver stalls
    int rx_hold;         // cycles left in a forced receiver hold-off
    int cycle_count;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hold off fully while rx_hold counts down.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_hold != 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the edge, before the drivers move.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_unit(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_byte(m_tdata, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one unit and hold it until the block takes the beat. Idle cycles
    // come before the beat; tvalid stays high straight into the next beat
    // when no idle is drawn.
    task automatic send_unit(input logic [31:0] unit, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop tvalid and wait until every predicted byte has come out, then
    // let the pipeline settle (a held unit or an out-of-range code point
    // leaves nothing to wait for).
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write wide_units; only called with the block idle.
    task automatic write_mode(input bit wide);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= wide;
        @(posedge clk);
        tracker.set_mode(wide);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random unit helpers
    // ------------------------------------------------------------------------

    // In UTF-16 mode the upper half is ignored; fill it with noise now and then.
    function automatic logic [31:0] with_noise(input logic [15:0] u);
        logic [31:0] r;
        r = $urandom();
        return ($urandom_range(0, 3) == 0) ? {r[31:16], u} : {16'b0, u};
    endfunction

    function automatic logic [15:0] rand_bmp();
        unique case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'($urandom_range(HIGH_FIRST, HIGH_END));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'($urandom_range(LOW_FIRST, LOW_END));
    endfunction

    // Mostly well-formed UTF-16 text, with broken pairs and raw noise mixed in.
    task automatic run_utf16_units(input int n_units, input int pause_at);
        int          sent;
        int          pick;
        bit          paused;
        logic [31:0] raw;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_units)
        begin
            // Pause the sender once until the block has gone quiet.
            if (!paused && pause_at > 0 && sent >= pause_at)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                send_unit(with_noise(rand_bmp()), $urandom_range(0, 7) == 0);
                sent += 1;
            end
            else if (pick < 75)
            begin
                // well-formed surrogate pair
                send_unit(with_noise(rand_high()), 1'b0);
                send_unit(with_noise(rand_low()), $urandom_range(0, 3) == 0);
                sent += 2;
            end
            else if (pick < 80)
            begin
                // high surrogate that ends the string
                send_unit(with_noise(rand_high()), 1'b1);
                sent += 1;
            end
            else if (pick < 86)
            begin
                // held high interrupted by a non-low unit
                send_unit(with_noise(rand_high()), 1'b0);
                send_unit(with_noise(($urandom_range(0, 1) == 0) ? rand_bmp() : rand_high()),
                          1'($urandom_range(0, 1)));
                sent += 2;
            end
            else if (pick < 91)
            begin
                // unpaired low surrogate
                send_unit(with_noise(rand_low()), 1'($urandom_range(0, 1)));
                sent += 1;
            end
            else
            begin
                raw = $urandom();
                send_unit(raw, 1'($urandom_range(0, 1)));
                sent += 1;
            end
        end
    endtask

    // Code points across all byte lengths, plus out-of-range values.
    task automatic run_wide_units(input int n_units);
        int          pick;
        logic [31:0] cp;
        repeat (n_units)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                cp = $urandom_range(32'h0, 32'h7F);
            else if (pick < 40)
                cp = $urandom_range(32'h80, 32'h7FF);
            else if (pick < 60)
                cp = $urandom_range(32'h800, 32'hFFFF);
            else if (pick < 80)
                cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
            else if (pick < 92)
                cp = $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
            else
                cp = $urandom();
            send_unit(cp, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 0;
        cycle_count  = 0;

        // Hold reset, then release it for good.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed: UTF-16 mode ----------------------------------------
        write_mode(MODE_UTF16);
        send_unit(32'h0000_0000, 1'b1);   // lowest unit
        send_unit(32'h0000_007F, 1'b0);   // top of one byte
        send_unit(32'h0000_0080, 1'b0);   // bottom of two bytes
        send_unit(32'h0000_07FF, 1'b0);
        send_unit(32'h0000_0800, 1'b0);   // bottom of three bytes
        send_unit(32'h0000_FFFF, 1'b1);
        send_unit(32'h0000_D800, 1'b0);   // lowest pair -> U+10000
        send_unit(32'h0000_DC00, 1'b0);
        send_unit(32'h0000_DBFF, 1'b0);   // highest pair -> U+10FFFF
        send_unit(32'h0000_DFFF, 1'b1);
        send_unit(32'h0000_D800, 1'b1);   // high surrogate ending the string
        send_unit(32'h0000_DC00, 1'b0);   // unpaired low surrogate
        send_unit(32'h0000_D9AB, 1'b0);   // held unit flushed by a plain unit
        send_unit(32'hFFFF_0041, 1'b1);   //   whose upper half must be ignored
        send_unit(32'h0000_DA00, 1'b0);   // held unit flushed by a last high
        send_unit(32'h0000_DB00, 1'b1);
        send_unit(32'h0000_DBFF, 1'b0);   // left held: the mode write drops it
        drain();

        // ---- Directed: 32-bit code point mode -----------------------------
        write_mode(MODE_WIDE);
        send_unit(32'h0000_0000, 1'b0);
        send_unit(32'h0000_007F, 1'b1);
        send_unit(32'h0000_0080, 1'b0);
        send_unit(32'h0000_07FF, 1'b1);
        send_unit(32'h0000_0800, 1'b0);
        send_unit(32'h0000_D800, 1'b0);   // surrogate value encodes as 3 bytes
        send_unit(32'h0000_FFFF, 1'b1);
        send_unit(32'h0001_0000, 1'b0);
        send_unit(32'h0010_FFFF, 1'b1);
        send_unit(32'h0011_0000, 1'b0);   // first out-of-range value: no bytes
        send_unit(32'hFFFF_FFFF, 1'b1);   // largest input: no bytes
        send_unit(32'h0000_0041, 1'b0);
        drain();

        // ---- Phase 1: no idling, long receiver hold-off, UTF-16 -----------
        // Hold the receiver off while the sender keeps pushing, so the job
        // queue fills and s_tready drops.
        write_mode(MODE_UTF16);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold     <= 400;
        run_utf16_units(80, 0);
        s_tvalid <= 1'b0;
        @(posedge clk);
        send_unit(with_noise(rand_high()), 1'b0);   // leave a unit held
        drain();

        // ---- Phase 2: sender idles, code points, one full pause -----------
        write_mode(MODE_WIDE);
        tx_idle_pct  = 48;
        rx_stall_pct = 0;
        run_wide_units(40);
        drain();
        run_wide_units(40);
        drain();

        // ---- Phase 3: receiver stalls, UTF-16 ----------------------------
        write_mode(MODE_UTF16);
        tx_idle_pct  = 0;
        rx_stall_pct = 48;
        run_utf16_units(80, 40);
        drain();

        // ---- Phase 4: both idle, code points then UTF-16 ------------------
        write_mode(MODE_WIDE);
        tx_idle_pct  = 18;
        rx_stall_pct = 18;
        run_wide_units(40);
        drain();
        write_mode(MODE_UTF16);
        run_utf16_units(40, 0);
        drain();

        tracker.close_out();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_fifo.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_encoder_core.sv
tb/tb_utf16_to_utf8_encoder_core.sv
